>>> hdl/toy_cpu_execute_unit_assert.svh
// Assertion macros for the execute unit.
`ifndef TOY_CPU_EXECUTE_UNIT_ASSERT_SVH
`define TOY_CPU_EXECUTE_UNIT_ASSERT_SVH
// Implication checked every cycle outside reset.
`define TCX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define TCX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hdl/tcx_pkg.sv
//------------------------------------------------------------------------------
// tcx_pkg
// Opcodes, fault codes and the queue entry type of the execute unit.
//------------------------------------------------------------------------------
package tcx_pkg;
   localparam logic [4:0] OP_LD_MEM = 5'd0;
   localparam logic [4:0] OP_LD_REG = 5'd1;
   localparam logic [4:0] OP_LD_IMM = 5'd2;
   localparam logic [4:0] OP_ST     = 5'd3;
   localparam logic [4:0] OP_ST_HI  = 5'd4;
   localparam logic [4:0] OP_ST_LO  = 5'd5;
   localparam logic [4:0] OP_CMP_R  = 5'd6;
   localparam logic [4:0] OP_CMP_I  = 5'd7;
   localparam logic [4:0] OP_ADD_I  = 5'd8;
   localparam logic [4:0] OP_ADD_R  = 5'd9;
   localparam logic [4:0] OP_SUB_I  = 5'd10;
   localparam logic [4:0] OP_SUB_R  = 5'd11;
   localparam logic [4:0] OP_MUL_I  = 5'd12;
   localparam logic [4:0] OP_DIV_I  = 5'd13;
   localparam logic [4:0] OP_MUL_R  = 5'd14;
   localparam logic [4:0] OP_DIV_R  = 5'd15;
   localparam logic [4:0] OP_JMP    = 5'd16;
   localparam logic [4:0] OP_JEQ    = 5'd17;
   localparam logic [4:0] OP_JGT    = 5'd18;
   localparam logic [4:0] OP_JLT    = 5'd19;
   localparam logic [4:0] OP_AND_I  = 5'd20;
   localparam logic [4:0] OP_AND_R  = 5'd21;
   localparam logic [4:0] OP_OR_I   = 5'd22;
   localparam logic [4:0] OP_OR_R   = 5'd23;
   localparam logic [4:0] OP_NOT_I  = 5'd24;
   localparam logic [4:0] OP_NOT_R  = 5'd25;
   localparam logic [4:0] OP_XOR_I  = 5'd26;
   localparam logic [4:0] OP_XOR_R  = 5'd27;
   localparam logic [4:0] OP_PUSH_I = 5'd28;
   localparam logic [4:0] OP_PUSH_R = 5'd29;
   localparam logic [4:0] OP_POP    = 5'd30;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_REG  = 2'd1;
   localparam logic [1:0] FAULT_DIV  = 2'd2;

   localparam logic [3:0] SP_INDEX = 4'd10;

   // classified instruction passed from front to back
   typedef struct packed {
      logic [4:0]  opcode;
      logic [3:0]  dest_reg;
      logic [3:0]  src_reg;
      logic [15:0] immediate;
      logic        use_src;
      logic        bad_reg;
   } instr_type;

   function automatic logic uses_dest(input logic [4:0] op);
      return (op <= OP_DIV_R) || (op >= OP_AND_I && op <= OP_XOR_R) ||
             op == OP_PUSH_R || op == OP_POP;
   endfunction

   function automatic logic uses_src(input logic [4:0] op);
      return op == OP_LD_REG || op == OP_CMP_R || op == OP_ADD_R || op == OP_SUB_R ||
             op == OP_MUL_R || op == OP_DIV_R || op == OP_AND_R || op == OP_OR_R ||
             op == OP_NOT_R || op == OP_XOR_R;
   endfunction
endpackage

>>> hdl/tcx_front.sv
//------------------------------------------------------------------------------
// tcx_front
// Accepts instructions, checks register indexes, queues them (two entries).
//------------------------------------------------------------------------------
module tcx_front #(
   parameter int NUM_REGS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [4:0]          req_opcode,
   input  logic [3:0]          req_dest_reg,
   input  logic [3:0]          req_src_reg,
   input  logic [15:0]         req_immediate,
   output logic                q_valid,
   input  logic                q_take,
   output tcx_pkg::instr_type  q_item
);
   tcx_pkg::instr_type slot_ff [2];
   tcx_pkg::instr_type slot_in;
   logic       wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.opcode    = req_opcode;
      slot_in.dest_reg  = req_dest_reg;
      slot_in.src_reg   = req_src_reg;
      slot_in.immediate = req_immediate;
      slot_in.use_src   = tcx_pkg::uses_src(req_opcode);
      slot_in.bad_reg   =
         (tcx_pkg::uses_dest(req_opcode) && {28'd0, req_dest_reg} >= NUM_REGS) ||
         (slot_in.use_src && {28'd0, req_src_reg} >= NUM_REGS);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= slot_in;
   end
endmodule

>>> hdl/tcx_divider.sv
//------------------------------------------------------------------------------
// tcx_divider
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module tcx_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   logic [15:0] quo_ff, quo_in, dsr_ff, dsr_in;
   logic [16:0] rem_ff, rem_in, trial;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;

   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == 5'd0);

   always_comb begin
      trial   = {rem_ff[15:0], quo_ff[15]} - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = 17'd0;
         dsr_in  = divisor;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != 5'd0) begin
         if (!trial[16]) rem_in = trial;
         else            rem_in = {rem_ff[15:0], quo_ff[15]};
         quo_in = {quo_ff[14:0], !trial[16]};
         cnt_in = cnt_ff - 5'd1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end
endmodule

>>> hdl/tcx_back.sv
//------------------------------------------------------------------------------
// tcx_back
// Executes queued instructions: register file, flags, data memory, divider.
//------------------------------------------------------------------------------
module tcx_back #(
   parameter int ADDR_BITS = 16,
   parameter int NUM_REGS  = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_take,
   input  tcx_pkg::instr_type  q_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_result_value,
   output logic                rsp_branch_taken,
   output logic [15:0]         rsp_branch_target,
   output logic                rsp_equal_flag,
   output logic                rsp_greater_flag,
   output logic                rsp_lower_flag,
   output logic [1:0]          rsp_fault
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_MEM  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [15:0] regs_ff [NUM_REGS];
   logic [7:0]  mem [2**ADDR_BITS];
   logic [7:0]  rd_byte_ff;
   logic        eq_ff, gt_ff, lt_ff;
   tcx_pkg::instr_type cur_ff;
   logic [15:0] a_ff, b_ff, sp_ff, prod_ff;
   logic [15:0] res_ff, tgt_ff;
   logic        tkn_ff;
   logic [1:0]  flt_ff;
   logic [3:0]  di, si;
   logic        div_start, div_done;
   logic [15:0] div_q;
   logic        mem_wr;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [7:0]  mem_wdata;
   logic        reg_wr;
   logic [3:0]  reg_idx;
   logic [15:0] reg_val;
   logic        sp_wr;
   logic [15:0] sp_val;
   logic        fin;
   logic [15:0] fin_res;
   logic        fin_tkn;
   logic [1:0]  fin_flt;
   logic        cmp_wr;

   tcx_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_take    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_result_value  = res_ff;
   assign rsp_branch_taken  = tkn_ff;
   assign rsp_branch_target = tgt_ff;
   assign rsp_equal_flag    = eq_ff;
   assign rsp_greater_flag  = gt_ff;
   assign rsp_lower_flag    = lt_ff;
   assign rsp_fault         = flt_ff;

   assign di = (q_item.bad_reg || {28'd0, q_item.dest_reg} >= NUM_REGS) ? 4'd0
               : q_item.dest_reg;
   assign si = (q_item.bad_reg || {28'd0, q_item.src_reg} >= NUM_REGS) ? 4'd0
               : q_item.src_reg;

   // execute one instruction per pass; a memory read passes through ST_MEM via rd_byte_ff
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      mem_wr    = 1'b0;
      mem_addr  = cur_ff.immediate[ADDR_BITS-1:0];
      mem_wdata = a_ff[7:0];
      reg_wr    = 1'b0;
      reg_idx   = cur_ff.dest_reg;
      reg_val   = 16'd0;
      sp_wr     = 1'b0;
      sp_val    = sp_ff;
      fin       = 1'b0;
      fin_res   = 16'd0;
      fin_tkn   = 1'b0;
      fin_flt   = tcx_pkg::FAULT_NONE;
      cmp_wr    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            fin = 1'b1;
            if (cur_ff.bad_reg) begin
               fin_flt = tcx_pkg::FAULT_REG;
            end else begin
               unique case (cur_ff.opcode)
                  tcx_pkg::OP_LD_MEM: begin
                     fin = 1'b0;
                     state_in = ST_MEM;
                  end
                  tcx_pkg::OP_POP: begin
                     fin = 1'b0;
                     mem_addr = sp_ff[ADDR_BITS-1:0];
                     state_in = ST_MEM;
                  end
                  tcx_pkg::OP_LD_REG, tcx_pkg::OP_LD_IMM: begin
                     reg_wr = 1'b1; reg_val = b_ff;
                  end
                  tcx_pkg::OP_ST, tcx_pkg::OP_ST_LO: begin
                     mem_wr = 1'b1; fin_res = {8'd0, a_ff[7:0]};
                  end
                  tcx_pkg::OP_ST_HI: begin
                     mem_wr = 1'b1; mem_wdata = a_ff[15:8];
                     fin_res = {8'd0, a_ff[15:8]};
                  end
                  tcx_pkg::OP_CMP_R, tcx_pkg::OP_CMP_I: cmp_wr = 1'b1;
                  tcx_pkg::OP_ADD_I, tcx_pkg::OP_ADD_R: begin
                     reg_wr = 1'b1; reg_val = a_ff + b_ff;
                  end
                  tcx_pkg::OP_SUB_I, tcx_pkg::OP_SUB_R: begin
                     reg_wr = 1'b1; reg_val = a_ff - b_ff;
                  end
                  tcx_pkg::OP_MUL_I, tcx_pkg::OP_MUL_R: begin
                     fin = 1'b0; state_in = ST_MUL;
                  end
                  tcx_pkg::OP_DIV_I, tcx_pkg::OP_DIV_R: begin
                     if (b_ff == 16'd0) begin
                        fin_flt = tcx_pkg::FAULT_DIV;
                     end else begin
                        fin = 1'b0; div_start = 1'b1; state_in = ST_DIV;
                     end
                  end
                  tcx_pkg::OP_JMP: fin_tkn = 1'b1;
                  tcx_pkg::OP_JEQ: fin_tkn = eq_ff;
                  tcx_pkg::OP_JGT: fin_tkn = gt_ff;
                  tcx_pkg::OP_JLT: fin_tkn = lt_ff;
                  tcx_pkg::OP_AND_I, tcx_pkg::OP_AND_R: begin
                     reg_wr = 1'b1; reg_val = a_ff & b_ff;
                  end
                  tcx_pkg::OP_OR_I, tcx_pkg::OP_OR_R: begin
                     reg_wr = 1'b1; reg_val = a_ff | b_ff;
                  end
                  tcx_pkg::OP_NOT_I, tcx_pkg::OP_NOT_R: begin
                     reg_wr = 1'b1; reg_val = ~b_ff;
                  end
                  tcx_pkg::OP_XOR_I, tcx_pkg::OP_XOR_R: begin
                     reg_wr = 1'b1; reg_val = a_ff ^ b_ff;
                  end
                  tcx_pkg::OP_PUSH_I, tcx_pkg::OP_PUSH_R: begin
                     mem_wr    = 1'b1;
                     mem_addr  = sp_val[ADDR_BITS-1:0] - {{(ADDR_BITS-1){1'b0}}, 1'b1};
                     mem_wdata = (cur_ff.opcode == tcx_pkg::OP_PUSH_I)
                                 ? cur_ff.immediate[7:0] : a_ff[7:0];
                     fin_res   = {8'd0, mem_wdata};
                     sp_wr     = 1'b1;
                     sp_val    = sp_ff - 16'd1;
                  end
                  default: ;
               endcase
            end
            if (reg_wr) fin_res = reg_val;
         end
         ST_MUL: begin
            fin = 1'b1; reg_wr = 1'b1; reg_val = prod_ff; fin_res = prod_ff;
         end
         ST_DIV: begin
            if (div_done) begin
               fin = 1'b1; reg_wr = 1'b1; reg_val = div_q; fin_res = div_q;
            end
         end
         ST_MEM: begin
            fin = 1'b1; reg_wr = 1'b1; reg_val = {8'd0, rd_byte_ff};
            fin_res = reg_val;
            if (cur_ff.opcode == tcx_pkg::OP_POP) begin
               sp_wr = 1'b1;
               // pop into the stack pointer increments the loaded value
               sp_val = (cur_ff.dest_reg == tcx_pkg::SP_INDEX)
                        ? reg_val + 16'd1 : sp_ff + 16'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (fin) state_in = ST_OUT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         eq_ff <= 1'b0; gt_ff <= 1'b0; lt_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= 16'd0;
      end else begin
         state_ff <= state_in;
         if (cmp_wr) begin
            eq_ff <= (a_ff == b_ff);
            gt_ff <= (a_ff > b_ff);
            lt_ff <= (a_ff < b_ff);
         end
         // stack pointer update wins over a register write to the same entry
         if (reg_wr && !(sp_wr && reg_idx == tcx_pkg::SP_INDEX))
            regs_ff[reg_idx] <= reg_val;
         if (sp_wr) regs_ff[tcx_pkg::SP_INDEX] <= sp_val;
      end
      if (q_take) begin
         cur_ff <= q_item;
         a_ff   <= regs_ff[di];
         b_ff   <= q_item.use_src ? regs_ff[si] : q_item.immediate;
         sp_ff  <= regs_ff[tcx_pkg::SP_INDEX];
      end
      prod_ff <= a_ff * b_ff;
      if (fin) begin
         res_ff <= fin_res;
         tkn_ff <= fin_tkn;
         tgt_ff <= fin_tkn ? cur_ff.immediate : 16'd0;
         flt_ff <= fin_flt;
      end
      if (mem_wr) mem[mem_addr] <= mem_wdata;
      rd_byte_ff <= mem[mem_addr];
   end
endmodule

>>> hdl/toy_cpu_execute_unit.sv
//------------------------------------------------------------------------------
// toy_cpu_execute_unit
// Execute stage of a small 16-bit machine with byte-wide data memory.
//------------------------------------------------------------------------------
// Usage: decoded instructions enter on the req_ channel (valid/stall); each
// item yields exactly one rsp_ item carrying the written value, branch
// decision, compare flags after the item and a fault code.
// A front part checks register indexes and holds up to two items in a
// queue, so the sender keeps going while the back part is busy.
// The back part works on one item at a time: it takes an item in IDLE,
// executes it in EXEC, passes loads and pops through MEM, multiplies
// through MUL and divides through DIV and the divider (a divide by zero
// faults in EXEC), then shows the result in OUT. It takes no new item
// until the result in OUT is accepted.
// Reset (synchronous, high) clears registers, flags and the queue; data
// memory is not cleared and reads of unwritten bytes are undefined.
// When rsp_stall is high the result holds; the queue keeps accepting
// until full, then req_stall rises.
//------------------------------------------------------------------------------
`include "toy_cpu_execute_unit_assert.svh"
module toy_cpu_execute_unit #(
   parameter int ADDR_BITS = 16,
   parameter int NUM_REGS  = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_opcode,
   input  logic [3:0]  req_dest_reg,
   input  logic [3:0]  req_src_reg,
   input  logic [15:0] req_immediate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_value,
   output logic        rsp_branch_taken,
   output logic [15:0] rsp_branch_target,
   output logic        rsp_equal_flag,
   output logic        rsp_greater_flag,
   output logic        rsp_lower_flag,
   output logic [1:0]  rsp_fault
);
   logic               q_valid, q_take;
   tcx_pkg::instr_type q_item;

   tcx_front #(.NUM_REGS(NUM_REGS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_dest_reg,
      .req_src_reg, .req_immediate, .q_valid, .q_take, .q_item
   );

   tcx_back #(.ADDR_BITS(ADDR_BITS), .NUM_REGS(NUM_REGS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item, .rsp_valid, .rsp_stall,
      .rsp_result_value, .rsp_branch_taken, .rsp_branch_target,
      .rsp_equal_flag, .rsp_greater_flag, .rsp_lower_flag, .rsp_fault
   );

   // never take from an empty queue
   `TCX_ASSERT_IMP(a_take_valid, clock, reset, q_take, q_valid, "take from empty queue")
   // a faulting item writes nothing and reports no value
   `TCX_ASSERT_IMP(a_fault_zero, clock, reset, rsp_valid && rsp_fault != tcx_pkg::FAULT_NONE,
      rsp_result_value == 16'd0 && !rsp_branch_taken, "fault with result")
   // a stalled result holds
   `TCX_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_value), "stalled result changed")
endmodule

>>> sim/toy_cpu_execute_unit_tb.sv
//------------------------------------------------------------------------------
// toy_cpu_execute_unit_tb
// Self-checking bench for the execute unit. It sends decoded instructions
// with random idle cycles and random result stalls. A scoreboard keeps its
// own copy of the registers, flags and data memory, predicts each result
// and compares every result against the oldest prediction, field by field.
//------------------------------------------------------------------------------
module toy_cpu_execute_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS = 11;
   localparam int N_ITEMS  = 1400;
   localparam logic [4:0] OP_UNUSED = 5'd31;

   typedef struct {
      logic [15:0] value;
      logic        taken;
      logic [15:0] target;
      logic        eq;
      logic        gt;
      logic        lt;
      logic [1:0]  fault;
   } exec_result_type;

   // Architectural shadow of the unit plus the queue of predicted results.
   class exec_scoreboard;
      logic [15:0]     regs [16];
      logic            eq_f, gt_f, lt_f;
      logic [7:0]      mem [int];
      logic [15:0]     stored_addrs [$];
      exec_result_type pending_q [$];
      int              errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         eq_f = 0; gt_f = 0; lt_f = 0;
         errors = 0;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function bit is_stored(logic [15:0] addr);
         return mem.exists(int'(addr));
      endfunction

      function void poke(logic [15:0] addr, logic [7:0] data);
         if (!mem.exists(int'(addr))) stored_addrs.push_back(addr);
         mem[int'(addr)] = data;
      endfunction

      function logic [7:0] peek(logic [15:0] addr);
         return mem.exists(int'(addr)) ? mem[int'(addr)] : 8'h00;
      endfunction

      // Execute one instruction on the shadow state and queue its result.
      function void note_request(logic [4:0] op, logic [3:0] d, logic [3:0] s,
                                 logic [15:0] imm);
         logic [15:0]     a, b, w, sp;
         bit              wr, ud, us;
         exec_result_type r;
         r = '{default: '0};
         wr = 0;
         w = '0;
         ud = (op <= tcx_pkg::OP_DIV_R) ||
              (op >= tcx_pkg::OP_AND_I && op <= tcx_pkg::OP_XOR_R) ||
              op == tcx_pkg::OP_PUSH_R || op == tcx_pkg::OP_POP;
         us = op inside {tcx_pkg::OP_LD_REG, tcx_pkg::OP_CMP_R, tcx_pkg::OP_ADD_R,
                         tcx_pkg::OP_SUB_R, tcx_pkg::OP_MUL_R, tcx_pkg::OP_DIV_R,
                         tcx_pkg::OP_AND_R, tcx_pkg::OP_OR_R, tcx_pkg::OP_NOT_R,
                         tcx_pkg::OP_XOR_R};
         if ((ud && d >= NUM_REGS) || (us && s >= NUM_REGS)) begin
            r.fault = tcx_pkg::FAULT_REG;
         end else begin
            a  = regs[d];
            b  = us ? regs[s] : imm;
            sp = regs[tcx_pkg::SP_INDEX];
            case (op)
               tcx_pkg::OP_LD_MEM: begin w = {8'h00, peek(imm)}; wr = 1; end
               tcx_pkg::OP_LD_REG, tcx_pkg::OP_LD_IMM: begin w = b; wr = 1; end
               tcx_pkg::OP_ST, tcx_pkg::OP_ST_LO: begin
                  r.value = {8'h00, a[7:0]}; poke(imm, a[7:0]);
               end
               tcx_pkg::OP_ST_HI: begin
                  r.value = {8'h00, a[15:8]}; poke(imm, a[15:8]);
               end
               tcx_pkg::OP_CMP_R, tcx_pkg::OP_CMP_I: begin
                  eq_f = (a == b); gt_f = (a > b); lt_f = (a < b);
               end
               tcx_pkg::OP_ADD_I, tcx_pkg::OP_ADD_R: begin w = a + b; wr = 1; end
               tcx_pkg::OP_SUB_I, tcx_pkg::OP_SUB_R: begin w = a - b; wr = 1; end
               tcx_pkg::OP_MUL_I, tcx_pkg::OP_MUL_R: begin w = a * b; wr = 1; end
               tcx_pkg::OP_DIV_I, tcx_pkg::OP_DIV_R: begin
                  if (b == 0) r.fault = tcx_pkg::FAULT_DIV;
                  else begin w = a / b; wr = 1; end
               end
               tcx_pkg::OP_JMP: r.taken = 1;
               tcx_pkg::OP_JEQ: r.taken = eq_f;
               tcx_pkg::OP_JGT: r.taken = gt_f;
               tcx_pkg::OP_JLT: r.taken = lt_f;
               tcx_pkg::OP_AND_I, tcx_pkg::OP_AND_R: begin w = a & b; wr = 1; end
               tcx_pkg::OP_OR_I, tcx_pkg::OP_OR_R:   begin w = a | b; wr = 1; end
               tcx_pkg::OP_NOT_I, tcx_pkg::OP_NOT_R: begin w = ~b; wr = 1; end
               tcx_pkg::OP_XOR_I, tcx_pkg::OP_XOR_R: begin w = a ^ b; wr = 1; end
               tcx_pkg::OP_PUSH_I, tcx_pkg::OP_PUSH_R: begin
                  r.value = {8'h00, (op == tcx_pkg::OP_PUSH_I) ? imm[7:0] : a[7:0]};
                  poke(sp - 16'd1, r.value[7:0]);
                  regs[tcx_pkg::SP_INDEX] = sp - 16'd1;
               end
               tcx_pkg::OP_POP: begin
                  // byte lands first, then SP bumps (matters for pop into SP)
                  r.value = {8'h00, peek(sp)};
                  regs[d] = r.value;
                  regs[tcx_pkg::SP_INDEX] = regs[tcx_pkg::SP_INDEX] + 16'd1;
               end
               default: ;
            endcase
            if (wr) begin
               r.value = w;
               regs[d] = w;
            end
            if (r.taken) r.target = imm;
         end
         r.eq = eq_f; r.gt = gt_f; r.lt = lt_f;
         pending_q.push_back(r);
      endfunction

      function void check_response(exec_result_type got);
         exec_result_type e;
         if (pending_q.size() == 0) begin
            $error("result with no instruction outstanding");
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.value !== e.value) begin
            $error("result_value exp %h got %h", e.value, got.value); errors++;
         end
         if (got.taken !== e.taken) begin
            $error("branch_taken exp %b got %b", e.taken, got.taken); errors++;
         end
         if (got.target !== e.target) begin
            $error("branch_target exp %h got %h", e.target, got.target); errors++;
         end
         if (got.eq !== e.eq) begin
            $error("equal_flag exp %b got %b", e.eq, got.eq); errors++;
         end
         if (got.gt !== e.gt) begin
            $error("greater_flag exp %b got %b", e.gt, got.gt); errors++;
         end
         if (got.lt !== e.lt) begin
            $error("lower_flag exp %b got %b", e.lt, got.lt); errors++;
         end
         if (got.fault !== e.fault) begin
            $error("fault exp %h got %h", e.fault, got.fault); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_opcode = '0;
   logic [3:0]  req_dest_reg = '0;
   logic [3:0]  req_src_reg = '0;
   logic [15:0] req_immediate = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result_value;
   logic        rsp_branch_taken;
   logic [15:0] rsp_branch_target;
   logic        rsp_equal_flag;
   logic        rsp_greater_flag;
   logic        rsp_lower_flag;
   logic [1:0]  rsp_fault;

   // no idling on either side while set
   bit calm = 0;

   exec_scoreboard sb = new();

   toy_cpu_execute_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_dest_reg      (req_dest_reg),
      .req_src_reg       (req_src_reg),
      .req_immediate     (req_immediate),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_branch_target (rsp_branch_target),
      .rsp_equal_flag    (rsp_equal_flag),
      .rsp_greater_flag  (rsp_greater_flag),
      .rsp_lower_flag    (rsp_lower_flag),
      .rsp_fault         (rsp_fault)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stalls, check every accepted item.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response('{rsp_result_value, rsp_branch_taken, rsp_branch_target,
                                rsp_equal_flag, rsp_greater_flag, rsp_lower_flag,
                                rsp_fault});
         rsp_stall <= !calm && ($urandom_range(99) < 23);
      end
   end

   // Mostly legal register indexes, now and then a bad one.
   function automatic logic [3:0] pick_reg();
      return ($urandom_range(99) < 6) ? 4'($urandom_range(15, 11))
                                      : 4'($urandom_range(10));
   endfunction

   function automatic logic [15:0] pick_imm();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Drive one item and hold it until accepted; predict at acceptance.
   // Loads and pops are steered so they only touch bytes already written.
   task automatic issue(input logic [4:0] op, input logic [3:0] d, input logic [3:0] s,
                        input logic [15:0] imm);
      if (op == tcx_pkg::OP_LD_MEM) begin
         if (sb.stored_addrs.size() == 0) op = tcx_pkg::OP_ST;
         else imm = sb.stored_addrs[$urandom_range(sb.stored_addrs.size() - 1)];
      end
      if (op == tcx_pkg::OP_POP && !sb.is_stored(sb.regs[tcx_pkg::SP_INDEX]))
         op = tcx_pkg::OP_PUSH_I;
      while (!calm && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_dest_reg  <= d;
      req_src_reg   <= s;
      req_immediate <= imm;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, d, s, imm);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   initial begin
      int n, k;
      logic [4:0] op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, faults, flag-driven jumps, stack corner cases.
      issue(tcx_pkg::OP_LD_IMM, 4'd0, 4'd0, 16'hFFFF);
      issue(tcx_pkg::OP_ST, 4'd0, 4'd0, 16'h0000);
      issue(tcx_pkg::OP_ST_HI, 4'd0, 4'd0, 16'hFFFF);
      issue(tcx_pkg::OP_ADD_I, 4'd0, 4'd0, 16'h0001);   // wraps to zero
      issue(tcx_pkg::OP_DIV_I, 4'd1, 4'd0, 16'h0000);   // divide by zero
      issue(tcx_pkg::OP_DIV_R, 4'd15, 4'd2, 16'h0000);  // bad index wins
      issue(tcx_pkg::OP_ADD_R, 4'd3, 4'd11, 16'h1234);  // bad source index
      issue(tcx_pkg::OP_CMP_I, 4'd0, 4'd0, 16'hFFFF);
      issue(tcx_pkg::OP_JLT, 4'd0, 4'd0, 16'hABCD);
      issue(OP_UNUSED, 4'd15, 4'd15, 16'hFFFF);
      issue(tcx_pkg::OP_PUSH_I, 4'd0, 4'd0, 16'h00A5);
      issue(tcx_pkg::OP_POP, tcx_pkg::SP_INDEX, 4'd0, 16'h0000); // pop into SP
      for (int i = 0; i < 32; i++)
         issue(5'(i), 4'(i % 11), 4'((i + 3) % 11),
               (i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0000 : 16'($urandom));

      // Hold off until the unit is empty once.
      drain();

      n = 0;
      while (n < N_ITEMS) begin
         calm = (n >= 500 && n < 700);
         k = $urandom_range(99);
         if (k < 15) begin
            // stack burst: pushes then matching pops
            int depth;
            depth = $urandom_range(1, 4);
            for (int j = 0; j < depth; j++)
               issue($urandom_range(1) ? tcx_pkg::OP_PUSH_R : tcx_pkg::OP_PUSH_I,
                     pick_reg(), pick_reg(), pick_imm());
            for (int j = 0; j < depth; j++)
               issue(tcx_pkg::OP_POP, pick_reg(), pick_reg(), pick_imm());
            n += 2 * depth;
         end else if (k < 30) begin
            issue($urandom_range(1) ? tcx_pkg::OP_CMP_R : tcx_pkg::OP_CMP_I,
                  pick_reg(), pick_reg(), pick_imm());
            issue(5'($urandom_range(tcx_pkg::OP_JMP, tcx_pkg::OP_JLT)),
                  pick_reg(), pick_reg(), pick_imm());
            n += 2;
         end else begin
            op = ($urandom_range(99) < 2) ? OP_UNUSED
                                          : 5'($urandom_range(tcx_pkg::OP_POP));
            issue(op, pick_reg(), pick_reg(), pick_imm());
            n++;
         end
      end
      calm = 0;

      drain();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end
endmodule
